@@ rtl/iee_pkg.sv @@
// Shared types, character codes and state encodings for the expression evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int LINE_LIMIT  = 128;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [7:0]             char_t;
    typedef logic [CNT_WIDTH-1:0]   iter_cnt_t;

    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_STAR  = 8'h2A;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_PCT   = 8'h25;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DIV0  = 2'd1,
        STAT_BADOP = 2'd2
    } status_t;

    // parse position within a line
    typedef enum logic [2:0] {
        PH_LEAD1 = 3'd0,
        PH_DIG1  = 3'd1,
        PH_SP1   = 3'd2,
        PH_LEAD2 = 3'd3,
        PH_DIG2  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    // sequencer for the evaluation at line end
    typedef enum logic [2:0] {
        CT_PARSE = 3'd0,
        CT_PREP  = 3'd1,
        CT_ITER  = 3'd2,
        CT_FIX   = 3'd3,
        CT_DONE  = 3'd4
    } ctrl_t;

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // m * 10 + digit, wrapping at VALUE_WIDTH; the digit is the low nibble
    function automatic value_t accumulate(input value_t m, input char_t c);
        return value_t'(m << 3) + value_t'(m << 1) + value_t'(c[3:0]);
    endfunction

endpackage

`default_nettype wire

@@ rtl/integer_expression_evaluator_core.sv @@
// Top level of the expression evaluator: character parser, bit-serial multiply/divide
// sequencer and output register. Depends on iee_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One character beat is taken per cycle while a line is being parsed. A beat with
// s_line_end set closes the line: for + and - (and for an error status) the PREP state
// computes the result and DONE loads it into the output register; for * / and % the
// block runs a shift-add multiplier or a restoring divider that produces one bit per
// cycle in ITER, then FIX, so s_ready stays low from PREP through DONE. The result
// sits in an output register, so the next line can be parsed while m_valid waits for m_ready.
module integer_expression_evaluator_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_ch,
    input  wire logic               s_line_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_result_value,
    output logic signed [31:0]      m_left_operand,
    output logic signed [31:0]      m_right_operand,
    output logic [7:0]              m_operator_char,
    output logic [1:0]              m_status
);

    iee_pkg::ctrl_t     ctrl_reg, ctrl_next;
    iee_pkg::phase_t    phase_reg, phase_next;
    iee_pkg::value_t    mag1_reg, mag1_next;
    logic               neg1_reg, neg1_next;
    iee_pkg::value_t    mag2_reg, mag2_next;
    logic               neg2_reg, neg2_next;
    iee_pkg::char_t     hop_reg, hop_next;
    logic [7:0]         char_cnt_reg, char_cnt_next;

    iee_pkg::value_t    a_reg, a_next;
    iee_pkg::value_t    b_reg, b_next;
    iee_pkg::char_t     op_reg, op_next;
    iee_pkg::status_t   stat_reg, stat_next;
    iee_pkg::value_t    res_reg, res_next;
    iee_pkg::value_t    work_reg, work_next;
    iee_pkg::value_t    acc_reg, acc_next;
    iee_pkg::value_t    opnd_reg, opnd_next;
    iee_pkg::iter_cnt_t iter_cnt_reg, iter_cnt_next;

    logic               m_valid_reg, m_valid_next;
    iee_pkg::value_t    out_res_reg, out_res_next;
    iee_pkg::value_t    out_a_reg, out_a_next;
    iee_pkg::value_t    out_b_reg, out_b_next;
    iee_pkg::char_t     out_op_reg, out_op_next;
    iee_pkg::status_t   out_stat_reg, out_stat_next;

    logic                         s_fire;
    logic                         is_mul, is_div, is_rem;
    logic [iee_pkg::VALUE_WIDTH:0] rem_sh;
    logic [iee_pkg::VALUE_WIDTH:0] rem_diff;

    assign s_ready = (ctrl_reg == iee_pkg::CT_PARSE);
    assign s_fire  = s_valid && s_ready;

    assign is_mul = (op_reg == iee_pkg::CH_STAR);
    assign is_div = (op_reg == iee_pkg::CH_SLASH);
    assign is_rem = (op_reg == iee_pkg::CH_PCT);

    // restoring divider step: shift one dividend bit into the partial remainder
    assign rem_sh   = {acc_reg, work_reg[iee_pkg::VALUE_WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, opnd_reg};

    always_comb begin
        iee_pkg::value_t ua;
        iee_pkg::value_t ub;
        ctrl_next     = ctrl_reg;
        phase_next    = phase_reg;
        mag1_next     = mag1_reg;
        neg1_next     = neg1_reg;
        mag2_next     = mag2_reg;
        neg2_next     = neg2_reg;
        hop_next      = hop_reg;
        char_cnt_next = char_cnt_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        op_next       = op_reg;
        stat_next     = stat_reg;
        res_next      = res_reg;
        work_next     = work_reg;
        acc_next      = acc_reg;
        opnd_next     = opnd_reg;
        iter_cnt_next = iter_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_res_next  = out_res_reg;
        out_a_next    = out_a_reg;
        out_b_next    = out_b_reg;
        out_op_next   = out_op_reg;
        out_stat_next = out_stat_reg;
        ua = a_reg[iee_pkg::VALUE_WIDTH-1] ? iee_pkg::value_t'(0) - a_reg : a_reg;
        ub = b_reg[iee_pkg::VALUE_WIDTH-1] ? iee_pkg::value_t'(0) - b_reg : b_reg;

        case (ctrl_reg)
            iee_pkg::CT_PARSE: begin
                if (s_fire && s_line_end) begin
                    a_next  = neg1_reg ? iee_pkg::value_t'(0) - mag1_reg : mag1_reg;
                    b_next  = neg2_reg ? iee_pkg::value_t'(0) - mag2_reg : mag2_reg;
                    op_next = hop_reg;
                    phase_next    = iee_pkg::PH_LEAD1;
                    mag1_next     = '0;
                    neg1_next     = 1'b0;
                    mag2_next     = '0;
                    neg2_next     = 1'b0;
                    hop_next      = '0;
                    char_cnt_next = '0;
                    ctrl_next     = iee_pkg::CT_PREP;
                end else if (s_fire && (char_cnt_reg < 8'(iee_pkg::LINE_LIMIT))) begin
                    char_cnt_next = char_cnt_reg + 8'd1;
                    case (phase_reg)
                        iee_pkg::PH_LEAD1: begin
                            if (s_ch == iee_pkg::CH_SPACE) begin
                            end else if (s_ch == iee_pkg::CH_MINUS) begin
                                neg1_next  = 1'b1;
                                phase_next = iee_pkg::PH_DIG1;
                            end else if (iee_pkg::is_digit(s_ch)) begin
                                mag1_next  = iee_pkg::accumulate(mag1_reg, s_ch);
                                phase_next = iee_pkg::PH_DIG1;
                            end else begin
                                hop_next   = s_ch;
                                phase_next = iee_pkg::PH_LEAD2;
                            end
                        end
                        iee_pkg::PH_DIG1: begin
                            if (iee_pkg::is_digit(s_ch)) begin
                                mag1_next = iee_pkg::accumulate(mag1_reg, s_ch);
                            end else if (s_ch == iee_pkg::CH_SPACE) begin
                                phase_next = iee_pkg::PH_SP1;
                            end else begin
                                hop_next   = s_ch;
                                phase_next = iee_pkg::PH_LEAD2;
                            end
                        end
                        iee_pkg::PH_SP1: begin
                            if (s_ch != iee_pkg::CH_SPACE) begin
                                hop_next   = s_ch;
                                phase_next = iee_pkg::PH_LEAD2;
                            end
                        end
                        iee_pkg::PH_LEAD2: begin
                            if (s_ch == iee_pkg::CH_SPACE) begin
                            end else if (s_ch == iee_pkg::CH_MINUS) begin
                                neg2_next  = 1'b1;
                                phase_next = iee_pkg::PH_DIG2;
                            end else if (iee_pkg::is_digit(s_ch)) begin
                                mag2_next  = iee_pkg::accumulate(mag2_reg, s_ch);
                                phase_next = iee_pkg::PH_DIG2;
                            end else begin
                                phase_next = iee_pkg::PH_DONE;
                            end
                        end
                        iee_pkg::PH_DIG2: begin
                            if (iee_pkg::is_digit(s_ch)) begin
                                mag2_next = iee_pkg::accumulate(mag2_reg, s_ch);
                            end else begin
                                phase_next = iee_pkg::PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            iee_pkg::CT_PREP: begin
                iter_cnt_next = '0;
                stat_next     = iee_pkg::STAT_OK;
                res_next      = '0;
                ctrl_next     = iee_pkg::CT_DONE;
                if (op_reg == iee_pkg::CH_PLUS) begin
                    res_next = a_reg + b_reg;
                end else if (op_reg == iee_pkg::CH_MINUS) begin
                    res_next = a_reg - b_reg;
                end else if (is_mul) begin
                    acc_next  = '0;
                    opnd_next = a_reg;
                    work_next = b_reg;
                    ctrl_next = iee_pkg::CT_ITER;
                end else if (is_div || is_rem) begin
                    if (b_reg == '0) begin
                        stat_next = iee_pkg::STAT_DIV0;
                    end else begin
                        acc_next  = '0;
                        opnd_next = ub;
                        work_next = ua;
                        ctrl_next = iee_pkg::CT_ITER;
                    end
                end else begin
                    stat_next = iee_pkg::STAT_BADOP;
                end
            end
            iee_pkg::CT_ITER: begin
                if (is_mul) begin
                    // shift-add: one multiplier bit per beat of the clock
                    if (work_reg[0]) begin
                        acc_next = acc_reg + opnd_reg;
                    end
                    opnd_next = opnd_reg << 1;
                    work_next = work_reg >> 1;
                end else if (!rem_diff[iee_pkg::VALUE_WIDTH]) begin
                    acc_next  = rem_diff[iee_pkg::VALUE_WIDTH-1:0];
                    work_next = {work_reg[iee_pkg::VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    acc_next  = rem_sh[iee_pkg::VALUE_WIDTH-1:0];
                    work_next = {work_reg[iee_pkg::VALUE_WIDTH-2:0], 1'b0};
                end
                if (iter_cnt_reg == iee_pkg::iter_cnt_t'(iee_pkg::VALUE_WIDTH - 1)) begin
                    iter_cnt_next = '0;
                    ctrl_next     = iee_pkg::CT_FIX;
                end else begin
                    iter_cnt_next = iter_cnt_reg + 1'b1;
                end
            end
            iee_pkg::CT_FIX: begin
                // work holds the quotient, acc the product or remainder
                if (is_mul) begin
                    res_next = acc_reg;
                end else if (is_div) begin
                    res_next = (a_reg[iee_pkg::VALUE_WIDTH-1] ^ b_reg[iee_pkg::VALUE_WIDTH-1])
                             ? iee_pkg::value_t'(0) - work_reg : work_reg;
                end else begin
                    res_next = a_reg[iee_pkg::VALUE_WIDTH-1]
                             ? iee_pkg::value_t'(0) - acc_reg : acc_reg;
                end
                ctrl_next = iee_pkg::CT_DONE;
            end
            iee_pkg::CT_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    out_res_next  = res_reg;
                    out_a_next    = a_reg;
                    out_b_next    = b_reg;
                    out_op_next   = op_reg;
                    out_stat_next = stat_reg;
                    ctrl_next     = iee_pkg::CT_PARSE;
                end
            end
            default: begin
                ctrl_next = iee_pkg::CT_PARSE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg     <= iee_pkg::CT_PARSE;
            phase_reg    <= iee_pkg::PH_LEAD1;
            mag1_reg     <= '0;
            neg1_reg     <= 1'b0;
            mag2_reg     <= '0;
            neg2_reg     <= 1'b0;
            hop_reg      <= '0;
            char_cnt_reg <= '0;
            iter_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            ctrl_reg     <= ctrl_next;
            phase_reg    <= phase_next;
            mag1_reg     <= mag1_next;
            neg1_reg     <= neg1_next;
            mag2_reg     <= mag2_next;
            neg2_reg     <= neg2_next;
            hop_reg      <= hop_next;
            char_cnt_reg <= char_cnt_next;
            iter_cnt_reg <= iter_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        op_reg       <= op_next;
        stat_reg     <= stat_next;
        res_reg      <= res_next;
        work_reg     <= work_next;
        acc_reg      <= acc_next;
        opnd_reg     <= opnd_next;
        out_res_reg  <= out_res_next;
        out_a_reg    <= out_a_next;
        out_b_reg    <= out_b_next;
        out_op_reg   <= out_op_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_value  = signed'(out_res_reg);
    assign m_left_operand  = signed'(out_a_reg);
    assign m_right_operand = signed'(out_b_reg);
    assign m_operator_char = out_op_reg;
    assign m_status        = out_stat_reg;

    // line end clears the parser and starts evaluation
    a_line_end_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_line_end) |=>
            (ctrl_reg == iee_pkg::CT_PREP) && (phase_reg == iee_pkg::PH_LEAD1)
            && (char_cnt_reg == 8'd0))
        else $error("line end did not restart the parser");

    a_char_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        char_cnt_reg <= 8'(iee_pkg::LINE_LIMIT))
        else $error("character count past line limit");

    a_iter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg != iee_pkg::CT_ITER) |-> (iter_cnt_reg == '0))
        else $error("iteration counter left running");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(ctrl_reg) == iee_pkg::CT_DONE))
        else $error("result beat not from the done state");

    a_div0_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_stat_reg == iee_pkg::STAT_DIV0)) |->
            ((out_op_reg == iee_pkg::CH_SLASH) || (out_op_reg == iee_pkg::CH_PCT)))
        else $error("divide by zero flagged for another operator");

endmodule

`default_nettype wire

@@ tb/iee_result_checker.sv @@
// Scoreboard for the expression evaluator: watches both channels, predicts one result per
// line from the accepted character beats and compares each result beat. Depends on iee_pkg.
`timescale 1ns / 1ps

module iee_result_checker
    import iee_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_ch,
    input  logic               s_line_end,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_result_value,
    input  logic signed [31:0] m_left_operand,
    input  logic signed [31:0] m_right_operand,
    input  logic [7:0]         m_operator_char,
    input  logic [1:0]         m_status,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        value_t  value;
        value_t  lhs;
        value_t  rhs;
        char_t   op;
        status_t status;
    } line_result_t;

    line_result_t expected_lines[$];
    int           mismatches;

    // parser state of the line in progress
    phase_t parse_pos;
    value_t lhs_mag;
    value_t rhs_mag;
    logic   lhs_neg;
    logic   rhs_neg;
    char_t  op_held;
    int     line_chars;

    task automatic clear_line();
        parse_pos  = PH_LEAD1;
        lhs_mag    = '0;
        rhs_mag    = '0;
        lhs_neg    = 1'b0;
        rhs_neg    = 1'b0;
        op_held    = '0;
        line_chars = 0;
    endtask

    task automatic parse_char(input char_t c);
        logic   dig;
        value_t digit_val;
        dig       = (c >= CH_ZERO) && (c <= CH_NINE);
        digit_val = value_t'(c - CH_ZERO);
        case (parse_pos)
            PH_LEAD1: begin
                if (c == CH_MINUS) begin
                    lhs_neg   = 1'b1;
                    parse_pos = PH_DIG1;
                end else if (dig) begin
                    lhs_mag   = value_t'(lhs_mag * 10 + digit_val);
                    parse_pos = PH_DIG1;
                end else if (c != CH_SPACE) begin
                    // operator where the first number should start
                    op_held   = c;
                    parse_pos = PH_LEAD2;
                end
            end
            PH_DIG1: begin
                if (dig) begin
                    lhs_mag = value_t'(lhs_mag * 10 + digit_val);
                end else if (c == CH_SPACE) begin
                    parse_pos = PH_SP1;
                end else begin
                    op_held   = c;
                    parse_pos = PH_LEAD2;
                end
            end
            PH_SP1: begin
                if (c != CH_SPACE) begin
                    op_held   = c;
                    parse_pos = PH_LEAD2;
                end
            end
            PH_LEAD2: begin
                if (c == CH_MINUS) begin
                    rhs_neg   = 1'b1;
                    parse_pos = PH_DIG2;
                end else if (dig) begin
                    rhs_mag   = value_t'(rhs_mag * 10 + digit_val);
                    parse_pos = PH_DIG2;
                end else if (c != CH_SPACE) begin
                    parse_pos = PH_DONE;
                end
            end
            PH_DIG2: begin
                if (dig) begin
                    rhs_mag = value_t'(rhs_mag * 10 + digit_val);
                end else begin
                    parse_pos = PH_DONE;
                end
            end
            default: ;
        endcase
    endtask

    function automatic line_result_t evaluate_line();
        line_result_t res;
        value_t       a, b, ua, ub, q, r;
        logic         a_neg, b_neg;
        a          = lhs_neg ? value_t'(-lhs_mag) : lhs_mag;
        b          = rhs_neg ? value_t'(-rhs_mag) : rhs_mag;
        a_neg      = a[VALUE_WIDTH-1];
        b_neg      = b[VALUE_WIDTH-1];
        res.value  = '0;
        res.lhs    = a;
        res.rhs    = b;
        res.op     = op_held;
        res.status = STAT_OK;
        case (op_held)
            CH_PLUS:  res.value = value_t'(a + b);
            CH_MINUS: res.value = value_t'(a - b);
            CH_STAR:  res.value = value_t'(a * b);
            CH_SLASH, CH_PCT: begin
                if (b == '0) begin
                    res.status = STAT_DIV0;
                end else begin
                    ua = a_neg ? value_t'(-a) : a;
                    ub = b_neg ? value_t'(-b) : b;
                    q  = ua / ub;
                    r  = ua % ub;
                    // truncating division; remainder follows the dividend's sign
                    if (op_held == CH_SLASH)
                        res.value = (a_neg != b_neg) ? value_t'(-q) : q;
                    else
                        res.value = a_neg ? value_t'(-r) : r;
                end
            end
            default:  res.status = STAT_BADOP;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        line_result_t exp_line;
        if (!aresetn) begin
            clear_line();
            expected_lines.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%t: result beat with nothing expected: ",
                                  "val=%0d lhs=%0d rhs=%0d op=%02h st=%0d"},
                                 $realtime, m_result_value, m_left_operand, m_right_operand,
                                 m_operator_char, m_status);
                end else begin
                    exp_line = expected_lines.pop_front();
                    if (m_result_value !== exp_line.value || m_left_operand !== exp_line.lhs ||
                        m_right_operand !== exp_line.rhs || m_operator_char !== exp_line.op ||
                        m_status !== exp_line.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t: result mismatch", $realtime);
                            $display("  exp val=%0d lhs=%0d rhs=%0d op=%02h st=%0d",
                                     $signed(exp_line.value), $signed(exp_line.lhs),
                                     $signed(exp_line.rhs), exp_line.op, exp_line.status);
                            $display("  got val=%0d lhs=%0d rhs=%0d op=%02h st=%0d",
                                     m_result_value, m_left_operand, m_right_operand,
                                     m_operator_char, m_status);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_line_end) begin
                    expected_lines.push_back(evaluate_line());
                    clear_line();
                end else if (line_chars < LINE_LIMIT) begin
                    parse_char(s_ch);
                    line_chars++;
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_lines.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for integer_expression_evaluator_core: clock, reset, character stimulus,
// result-side backpressure and verdict. Depends on iee_pkg and iee_result_checker.
`timescale 1ns / 1ps

module tb_top;
    import iee_pkg::*;

    logic               aclk       = 1'b0;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic [7:0]         s_ch       = 8'h00;
    logic               s_line_end = 1'b0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic signed [31:0] m_result_value;
    logic signed [31:0] m_left_operand;
    logic signed [31:0] m_right_operand;
    logic [7:0]         m_operator_char;
    logic [1:0]         m_status;

    int   fail_count;
    int   pending_count;
    logic calm       = 1'b0;   // no idling on either side while set
    int   beat_total = 0;
    char_t line_buf[$];

    localparam char_t OP_CODES [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT};

    integer_expression_evaluator_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_line_end      (s_line_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_left_operand  (m_left_operand),
        .m_right_operand (m_right_operand),
        .m_operator_char (m_operator_char),
        .m_status        (m_status)
    );

    iee_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_line_end      (s_line_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_left_operand  (m_left_operand),
        .m_right_operand (m_right_operand),
        .m_operator_char (m_operator_char),
        .m_status        (m_status),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    task automatic send_beat(input char_t c, input logic last);
        calm <= (beat_total >= 300) && (beat_total < 450);
        while (!calm && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_ch       <= c;
        s_line_end <= last;
        do @(posedge aclk); while (!s_ready);
        beat_total++;
    endtask

    // sends the buffered characters, then the line-end beat with a random ignored char
    task automatic send_line();
        foreach (line_buf[i])
            send_beat(line_buf[i], 1'b0);
        send_beat(char_t'($urandom_range(0, 255)), 1'b1);
        line_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(char_t'(s[i]));
    endtask

    task automatic add_digits(input int n);
        repeat (n) line_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
    endtask

    task automatic add_spaces();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
        repeat (n) line_buf.push_back(CH_SPACE);
    endtask

    task automatic add_number();
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(CH_MINUS);
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: add_digits($urandom_range(1, 3));
            5:  add_text("0");
            6:  add_text("2147483648");
            7:  add_text("2147483647");
            8:  add_digits(10);
            9:  add_digits($urandom_range(11, 14));   // wraps
            10: add_text("1");
            default: ;                               // sign or nothing only
        endcase
    endtask

    task automatic build_expression();
        add_spaces();
        add_number();
        add_spaces();
        if ($urandom_range(0, 9) == 0)
            line_buf.push_back(char_t'($urandom_range(0, 255)));
        else
            line_buf.push_back(OP_CODES[$urandom_range(0, 4)]);
        add_spaces();
        add_number();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) line_buf.push_back(char_t'($urandom_range(0, 255)));
    endtask

    initial begin
        int line_no;
        int drop;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lines
        add_text("-7%2");      send_line();
        add_text("8/0");       send_line();
        add_text("6*-3");      send_line();
        add_text("+1");        send_line();   // operator where a number should be
        send_line();                          // empty line, no operator
        add_text("1-2");       send_line();
        add_text("3?4");       send_line();
        line_buf.push_back(8'hFF);
        send_line();

        line_no = 0;
        while (beat_total < 740) begin
            line_no++;
            if (line_no == 20) begin
                // characters past the line limit must not reach the second number
                repeat (120) line_buf.push_back(CH_SPACE);
                add_text("12+34567890123");
            end else begin
                case ($urandom_range(0, 19))
                    0: repeat ($urandom_range(1, 8))
                           line_buf.push_back(char_t'($urandom_range(0, 255)));
                    1: begin
                        build_expression();
                        drop = $urandom_range(1, line_buf.size());
                        repeat (drop) void'(line_buf.pop_back());
                    end
                    2: begin
                        if ($urandom_range(0, 1) != 0)
                            add_text("-2147483648/-1");
                        else
                            add_text("-2147483648 % -1");
                    end
                    default: build_expression();
                endcase
            end
            send_line();
        end
        s_valid    <= 1'b0;
        s_line_end <= 1'b0;

        do @(posedge aclk); while (pending_count != 0);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
